// ----- rtl/estuc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// estuc_pkg
// Shared types, constants and calendar helpers for the epoch-to-calendar block.
// ----------------------------------------------------------------------------
package estuc_pkg;

    localparam int EPOCH_W = 32;
    localparam int DATA_W  = 48;     // 46 payload bits rounded up to bytes
    localparam int NUM_W   = 33;     // biased epoch width
    localparam int QUO_W   = 16;     // biased day number, below 49712
    localparam int REM_W   = 17;     // second of day, 86400 < 2**17
    localparam int DAYS_W  = 17;     // signed day count

    localparam logic [NUM_W-1:0]  EPOCH_BIAS = 33'd2147558400; // 24856 whole days
    localparam logic [NUM_W-1:0]  DAY_SECS   = 33'd86400;
    localparam logic [REM_W-1:0]  HOUR_SECS  = 17'd3600;
    localparam logic [REM_W-1:0]  MIN_SECS   = 17'd60;
    localparam logic [DAYS_W-1:0] DAY_BIAS   = 17'd24856;
    localparam logic [7:0]        BASE_YEAR  = 8'd70;          // 1970 - 1900

    // Reciprocals, ceil(2**k / d); exact for the operand ranges used here.
    // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15.
    localparam logic [26:0] DAY_RECIP  = 27'd101806633;  // 2**36 / 675
    localparam logic [16:0] WEEK_RECIP = 17'd74899;      // 2**19 / 7
    localparam logic [13:0] HOUR_RECIP = 14'd9321;       // 2**21 / 225
    localparam logic [10:0] MIN_RECIP  = 11'd1093;       // 2**14 / 15

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic quo_step;
        logic sod_step;
        logic hour_step;
        logic hrem_step;
        logic min_step;
        logic srem_step;
        logic year_step;
        logic month_init;
        logic month_step;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic year_done;
        logic month_done;
        logic out_busy;
    } sts_t;

    // y is the year minus 1900
    function automatic logic is_leap(input logic [7:0] y);
        return (y[1:0] == 2'b00) && (y != 8'd0) && (y != 8'd200);
    endfunction

    function automatic logic [8:0] year_len(input logic [7:0] y);
        return is_leap(y) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/epoch_seconds_to_utc_calendar.sv -----
`default_nettype none
// The year walk steps one year per cycle from 1970 (0..69 years), then the
//   month walk steps through month index 0..11 before the result is loaded.
// The next input is taken in the cycle after the result is loaded, and no
//   beat is taken while the year and month walks run.
// A finished result waits in the output register while the next beat is taken.
// Reset: aresetn synchronous active low; clears sequencer and m_tvalid.
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar
// Signed Unix seconds to broken-down UTC Gregorian calendar time.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_calendar
    import estuc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // slave side
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [EPOCH_W-1:0]  s_tdata,   // [31:0] epoch_seconds (signed)
    // master side
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [DATA_W-1:0]        m_tdata    // [5:0] second, [11:6] minute,
                                                // [16:12] hour, [21:17] day_of_month,
                                                // [25:22] month, [33:26] year_since_1900,
                                                // [42:34] day_of_year, [45:43] weekday,
                                                // [47:46] zero
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer: accept, day quotient, second of day, hour, minute and
    // second splits, year walk, month walk, then load the output register.
    estuc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: the epoch is biased by a whole number of days so that an
    // unsigned reciprocal multiply gives floor semantics for negative
    // times. Weekday is the biased day number mod 7, offset to Sunday = 0.
    estuc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .epoch    (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ----- rtl/estuc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// estuc_ctrl
// Sequencer: day split, time-of-day split, year walk, month walk, output.
// ----------------------------------------------------------------------------
module estuc_ctrl
    import estuc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_QUO   = 4'd1;
    localparam logic [3:0] ST_SOD   = 4'd2;
    localparam logic [3:0] ST_HOUR  = 4'd3;
    localparam logic [3:0] ST_HREM  = 4'd4;
    localparam logic [3:0] ST_MIN   = 4'd5;
    localparam logic [3:0] ST_SREM  = 4'd6;
    localparam logic [3:0] ST_YEAR  = 4'd7;
    localparam logic [3:0] ST_MONTH = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_QUO;
                end
            end
            ST_QUO: begin
                cmd.quo_step = 1'b1;
                state_next   = ST_SOD;
            end
            ST_SOD: begin
                cmd.sod_step = 1'b1;
                state_next   = ST_HOUR;
            end
            ST_HOUR: begin
                cmd.hour_step = 1'b1;
                state_next    = ST_HREM;
            end
            ST_HREM: begin
                cmd.hrem_step = 1'b1;
                state_next    = ST_MIN;
            end
            ST_MIN: begin
                cmd.min_step = 1'b1;
                state_next   = ST_SREM;
            end
            ST_SREM: begin
                cmd.srem_step = 1'b1;
                state_next    = ST_YEAR;
            end
            ST_YEAR: begin
                if (sts.year_done) begin
                    cmd.month_init = 1'b1;
                    state_next     = ST_MONTH;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH: begin
                if (sts.month_done) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/estuc_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// estuc_dp
// Datapath: reciprocal divide by 86400, hour/minute split, year and month walks.
// ----------------------------------------------------------------------------
module estuc_dp
    import estuc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [EPOCH_W-1:0]   epoch,
    input  wire cmd_t                 cmd,
    output sts_t                      sts,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [DATA_W-1:0]         m_tdata
);

    logic [NUM_W-1:0]  num_reg, num_next;     // biased epoch
    logic [QUO_W-1:0]  quo_reg, quo_next;     // biased day number
    logic [REM_W-1:0]  rem_reg, rem_next;     // second of day, then leftover seconds
    logic [13:0]       wq_reg, wq_next;       // day number / 7
    logic [2:0]        wk_reg, wk_next;       // day number mod 7
    logic [4:0]        hour_reg, hour_next;
    logic [5:0]        min_reg, min_next;
    logic [DAYS_W-1:0] days_reg, days_next;   // signed day count
    logic [7:0]        year_reg, year_next;
    logic [8:0]        doy_reg, doy_next;
    logic [3:0]        mon_reg, mon_next;
    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] data_reg, data_next;

    // day split
    logic [52:0]       quo_prod;
    logic [NUM_W-1:0]  quo_secs;
    logic [NUM_W-1:0]  sod_full;
    logic [32:0]       wq_prod;
    // time-of-day split
    logic [26:0]       hour_prod;
    logic [REM_W-1:0]  hour_secs;
    logic [20:0]       min_prod;
    logic [REM_W-1:0]  min_secs;
    // year / month walk
    logic              days_neg;
    logic [7:0]        year_dec;
    logic [8:0]        len_cur, len_dec;
    logic [4:0]        dim;
    // output assembly
    logic [3:0]        wd_sum;
    logic [2:0]        wd;
    logic [4:0]        dom;

    // floor(N / 86400) = floor((N >> 7) / 675)
    assign quo_prod  = num_reg[NUM_W-1:7] * DAY_RECIP;
    assign quo_secs  = {{(NUM_W-QUO_W){1'b0}}, quo_reg} * DAY_SECS;
    assign sod_full  = num_reg - quo_secs;
    assign wq_prod   = quo_reg * WEEK_RECIP;

    // floor(s / 3600) = floor((s >> 4) / 225), floor(s / 60) = floor((s >> 2) / 15)
    assign hour_prod = rem_reg[REM_W-1:4] * HOUR_RECIP;
    assign hour_secs = {{(REM_W-5){1'b0}}, hour_reg} * HOUR_SECS;
    assign min_prod  = rem_reg[11:2] * MIN_RECIP;
    assign min_secs  = {{(REM_W-6){1'b0}}, min_reg} * MIN_SECS;

    assign days_neg = days_reg[DAYS_W-1];
    assign year_dec = year_reg - 8'd1;
    assign len_cur  = year_len(year_reg);
    assign len_dec  = year_len(year_dec);
    assign dim      = month_len(mon_reg, is_leap(year_reg));

    assign wd_sum = {1'b0, wk_reg} + 4'd5;
    assign wd     = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
    assign dom    = days_reg[4:0] + 5'd1;

    assign sts.year_done  = !days_neg && (days_reg < {8'd0, len_cur});
    assign sts.month_done = (days_reg[8:0] < {4'd0, dim});
    assign sts.out_busy   = valid_reg && !m_tready;

    always_comb begin
        num_next   = num_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        wq_next    = wq_reg;
        wk_next    = wk_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        days_next  = days_reg;
        year_next  = year_reg;
        doy_next   = doy_reg;
        mon_next   = mon_reg;
        data_next  = data_reg;
        valid_next = valid_reg && !m_tready;

        if (cmd.load) begin
            num_next = {epoch[EPOCH_W-1], epoch} + EPOCH_BIAS;
        end
        if (cmd.quo_step) begin
            quo_next = quo_prod[51:36];
        end
        if (cmd.sod_step) begin
            rem_next  = sod_full[REM_W-1:0];
            wq_next   = wq_prod[32:19];
            days_next = {1'b0, quo_reg} - DAY_BIAS;
            year_next = BASE_YEAR;
        end
        if (cmd.hour_step) begin
            hour_next = hour_prod[25:21];
            // q - 7*(q/7) == q + q/7 mod 8, and the true value is below 7
            wk_next   = quo_reg[2:0] + wq_reg[2:0];
        end
        if (cmd.hrem_step) begin
            rem_next = rem_reg - hour_secs;
        end
        if (cmd.min_step) begin
            min_next = min_prod[19:14];
        end
        if (cmd.srem_step) begin
            rem_next = rem_reg - min_secs;
        end
        if (cmd.year_step) begin
            if (days_neg) begin
                days_next = days_reg + {8'd0, len_dec};
                year_next = year_dec;
            end else begin
                days_next = days_reg - {8'd0, len_cur};
                year_next = year_reg + 8'd1;
            end
        end
        if (cmd.month_init) begin
            doy_next = days_reg[8:0];
            mon_next = '0;
        end
        if (cmd.month_step) begin
            days_next = days_reg - {12'd0, dim};
            mon_next  = mon_reg + 4'd1;
        end
        if (cmd.out_load) begin
            valid_next = 1'b1;
            data_next  = {2'b00, wd, doy_reg, year_reg, mon_reg, dom,
                          hour_reg, min_reg, rem_reg[5:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        wq_reg   <= wq_next;
        wk_reg   <= wk_next;
        hour_reg <= hour_next;
        min_reg  <= min_next;
        days_reg <= days_next;
        year_reg <= year_next;
        doy_reg  <= doy_next;
        mon_reg  <= mon_next;
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

`ifndef SYNTHESIS
    // reciprocal quotient must leave a proper second of day
    a_day_split: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sod_step |-> (sod_full < DAY_SECS))
        else $error("day split left a bad second of day");

    // time-of-day split must leave a proper time of day
    a_tod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (hour_reg < 5'd24) && (min_reg < 6'd60) && (rem_reg < 17'd60))
        else $error("time of day out of range at output load");

    // month walk must end inside the month
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !days_neg && (days_reg < 17'd31) && (mon_reg < 4'd12))
        else $error("month walk ended out of range");

    // year walk hands over a nonnegative day of year
    a_year_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.month_init |-> !days_neg && (days_reg < 17'd366))
        else $error("year walk ended with bad day of year");
`endif

endmodule
`default_nettype wire

// ----- tb/epoch_seconds_to_utc_calendar_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar_test
// Self-checking bench for the epoch-to-calendar converter. Directed dates hit
// the range ends, midnight around the epoch, leap days and year ends; random
// epoch values then run under five flow-control mixes. Every result beat is
// checked field by field against a behavioral calendar predictor.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_calendar_test;

    localparam int CLK_HALF     = 10;       // 20 ns period
    localparam int DAY_SECONDS  = 86400;
    localparam int STALL_LIMIT  = 5000;     // cycles with no beat before giving up
    localparam int DRAIN_CYCLES = 140;      // extra wait after the drain, before the final check
    localparam int RANDOM_ITEMS = 276;      // per random phase

    // Broken-down UTC time, one entry per expected result beat
    typedef struct {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] mday;
        logic [3:0] month;
        logic [7:0] year;       // calendar year minus 1900
        logic [8:0] yday;
        logic [2:0] weekday;
    } calendar_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [estuc_pkg::EPOCH_W-1:0]  s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [estuc_pkg::DATA_W-1:0]   m_tdata;

    calendar_t expected_dates[$];
    int        gap_pct         = 0;         // chance per cycle the sender holds off
    int        stall_pct       = 0;         // chance per cycle the receiver stalls
    int        mismatch_count  = 0;
    int        epochs_sent     = 0;
    int        results_checked = 0;
    int        quiet_cycles    = 0;

    int days_in_month[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    epoch_seconds_to_utc_calendar dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------------
    function automatic bit gregorian_leap(input int yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int days_in_year(input int yr);
        return gregorian_leap(yr) ? 366 : 365;
    endfunction

    function automatic calendar_t calendar_of_epoch(input logic signed [31:0] secs);
        longint    t;
        longint    day_num;
        longint    sod;
        longint    wd;
        int        yr;
        int        d;
        int        mo;
        int        dim;
        calendar_t c;
        t       = secs;
        day_num = t / DAY_SECONDS;
        sod     = t % DAY_SECONDS;
        // floor division: negative times land on the earlier day
        if (sod < 0) begin
            sod     += DAY_SECONDS;
            day_num -= 1;
        end
        // the epoch day was a Thursday
        wd = (day_num + 4) % 7;
        if (wd < 0) begin
            wd += 7;
        end
        yr = 1970;
        if (day_num >= 0) begin
            while (day_num >= days_in_year(yr)) begin
                day_num -= days_in_year(yr);
                yr++;
            end
        end else begin
            while (day_num < 0) begin
                yr--;
                day_num += days_in_year(yr);
            end
        end
        d      = int'(day_num);
        c.yday = d[8:0];
        mo     = 0;
        while (mo < 12) begin
            dim = days_in_month[mo];
            if (mo == 1 && gregorian_leap(yr)) begin
                dim++;
            end
            if (d < dim) begin
                break;
            end
            d -= dim;
            mo++;
        end
        c.second  = 6'((sod % 3600) % 60);
        c.minute  = 6'((sod % 3600) / 60);
        c.hour    = 5'(sod / 3600);
        c.mday    = 5'(d + 1);
        c.month   = 4'(mo);
        c.year    = 8'(yr - 1900);
        c.weekday = 3'(wd);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // One input beat. Valid stays high from one beat to the next unless a gap
    // is rolled, so it is never dropped and raised in the same step.
    task automatic send_epoch(input logic [31:0] secs);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        do @(posedge aclk); while (!s_tready);
        expected_dates.push_back(calendar_of_epoch(secs));
        epochs_sent++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_dates.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Random epoch, weighted toward day, month and year boundaries where the
    // divider and the year/month walks are most likely to slip.
    function automatic logic [31:0] pick_epoch();
        logic [31:0] base;
        calendar_t   c;
        longint      sod;
        longint      t;
        int          off;
        base = $urandom;
        c    = calendar_of_epoch(base);
        sod  = c.hour * 3600 + c.minute * 60 + c.second;
        off  = int'($urandom_range(6)) - 3;
        case ($urandom_range(9))
            4, 5: t = longint'($signed(base)) - sod + off;                // around midnight
            6, 7: t = longint'($signed(base)) - sod - (c.mday - 1) * DAY_SECONDS
                      + off * DAY_SECONDS + (int'($urandom_range(2)) - 1); // month start
            8:    t = longint'($signed(base)) - sod - c.yday * DAY_SECONDS + off;
            9: begin
                case ($urandom_range(2))
                    0:       t = int'($urandom_range(400000)) - 200000;   // near the epoch
                    1:       t = 64'sd2147483647 - $urandom_range(200000);
                    default: t = -64'sd2147483648 + $urandom_range(200000);
                endcase
            end
            default: t = longint'($signed(base));
        endcase
        // out-of-range neighbors wrap to the other end, still a valid input
        return t[31:0];
    endfunction

    task automatic run_random_beats(input int count);
        repeat (count) send_epoch(pick_epoch());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_dates();
        gap_pct   = 0;
        stall_pct = 0;
        send_epoch(32'sd0);              // epoch itself, a Thursday
        send_epoch(-32'sd1);             // 1969-12-31 23:59:59, floor division
        send_epoch(32'sd1);
        send_epoch(32'sd86399);          // last second of day zero
        send_epoch(32'sd86400);          // first midnight
        send_epoch(-32'sd86400);         // 1969-12-31 00:00:00
        send_epoch(-32'sd86401);
        send_epoch(32'sh7FFF_FFFF);      // 2038-01-19 03:14:07, top of range
        send_epoch(32'sh8000_0000);      // 1901-12-13 20:45:52, bottom of range
        send_epoch(-32'sd2147472000);    // 1901-12-14 00:00:00
        send_epoch(32'sd2678399);        // end of January 1970
        send_epoch(32'sd28857600);       // 1970-12-01
        send_epoch(32'sd68169600);       // 1972-02-29, leap day
        send_epoch(32'sd68255999);       // 1972-02-29 23:59:59
        send_epoch(32'sd68256000);       // 1972-03-01
        send_epoch(-32'sd58060800);      // 1968-02-29, leap day before the epoch
        send_epoch(-32'sd631152000);     // 1950-01-01
        send_epoch(32'sd915148799);      // 1998-12-31 23:59:59, last day of a common year
        send_epoch(32'sd951782400);      // 2000-02-29, century leap by the 400 rule
        send_epoch(32'sd978307199);      // 2000-12-31 23:59:59, day of year 365
        send_epoch(32'sd1483228799);     // 2016-12-31 23:59:59
        send_epoch(32'sd1483228800);     // 2017-01-01
        send_epoch(32'h5555_5555);       // alternating bit patterns
        send_epoch(32'hAAAA_AAAA);
    endtask

    task automatic test_random_no_idle();
        gap_pct   = 0;
        stall_pct = 0;
        run_random_beats(RANDOM_ITEMS);
    endtask

    task automatic test_random_sender_idle();
        gap_pct   = 79;
        stall_pct = 0;
        run_random_beats(RANDOM_ITEMS);
    endtask

    task automatic test_random_receiver_stall();
        gap_pct   = 0;
        stall_pct = 79;
        run_random_beats(RANDOM_ITEMS);
    endtask

    task automatic test_random_both_idle();
        gap_pct   = 25;
        stall_pct = 25;
        run_random_beats(RANDOM_ITEMS);
    endtask

    // Sender stops until every result is back, then resumes from an empty block
    task automatic test_drain_then_resume();
        gap_pct   = 0;
        stall_pct = 50;
        run_random_beats(12);
        wait_for_drain();
        run_random_beats(12);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random backpressure per cycle, off when stall_pct is zero
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every accepted result beat against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        calendar_t got;
        calendar_t want;
        if (aresetn && m_tvalid && m_tready) begin
            // m_tdata fields, low bits first
            got.second  = m_tdata[5:0];
            got.minute  = m_tdata[11:6];
            got.hour    = m_tdata[16:12];
            got.mday    = m_tdata[21:17];
            got.month   = m_tdata[25:22];
            got.year    = m_tdata[33:26];
            got.yday    = m_tdata[42:34];
            got.weekday = m_tdata[45:43];
            if (expected_dates.size() == 0) begin
                $error("result beat with no input pending");
                mismatch_count++;
            end else begin
                want = expected_dates.pop_front();
                compare_field("second",          want.second,  got.second);
                compare_field("minute",          want.minute,  got.minute);
                compare_field("hour",            want.hour,    got.hour);
                compare_field("day_of_month",    want.mday,    got.mday);
                compare_field("month",           want.month,   got.month);
                compare_field("year_since_1900", want.year,    got.year);
                compare_field("day_of_year",     want.yday,    got.yday);
                compare_field("weekday",         want.weekday, got.weekday);
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any beat on either side resets the count
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_dates.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_dates();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_drain_then_resume();

        // all input taken; let the results come back, then wait DRAIN_CYCLES more
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_dates.size() != 0) begin
            $error("%0d results never arrived", expected_dates.size());
            mismatch_count++;
        end

        $display("Converted %0d epoch values (range ends, leap days, year ends, random)",
                 epochs_sent);
        $display("Checked %0d results under free flow, sender gaps and receiver stalls",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
